/* design/assert_macros.svh */
// Assertion macros shared by the SHA-1 stream hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sha1 stream hash check failed");
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sha1 stream hash check failed");
`else
`define CHK_ASSERT(label, clk, rst, prop)
`define CHK_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/sha1s_pkg.sv */
// Types, constants and command/status structs for the SHA-1 stream hash.
`default_nettype none
package sha1s_pkg;

  localparam int ROUNDS        = 80;
  localparam int ROUND_W       = $clog2(ROUNDS);
  localparam int BLOCK_WORDS   = 16;
  localparam int DIGEST_WORDS  = 5;
  localparam int IDX_W         = 3;
  localparam int FILL_W        = 6;
  localparam logic [FILL_W-1:0] LEN_FILL  = 6'd56;
  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [IDX_W-1:0] LAST_WORD_IDX = 3'd4;

  localparam logic [31:0] K_CH   = 32'h5a827999;
  localparam logic [31:0] K_PAR1 = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ  = 32'h8f1bbcdc;
  localparam logic [31:0] K_PAR2 = 32'hca62c1d6;

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD_MARK, S_PAD_ZERO, S_PAD_LEN, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_CH, PH_PAR1, PH_MAJ, PH_PAR2
  } round_phase_t;

  typedef enum logic [1:0] {
    BYTE_IN, BYTE_MARK, BYTE_ZERO, BYTE_LEN
  } byte_sel_t;

  typedef struct packed {
    logic             absorb;
    byte_sel_t        byte_sel;
    logic             count_byte;
    logic             load_work;
    logic             round;
    round_phase_t     phase;
    logic             add_chain;
    logic             init;
    logic             out_load;
    logic [IDX_W-1:0] out_index;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* design/sha1_stream_hash_top.sv */
// Top level of the streaming SHA-1 hash engine.
//
//  channel   dir  tdata                 tuser              tlast
//  s_*       in   [7:0] data_byte       [0] has_byte       finish
//  m_*       out  [31:0] digest_word    [2:0] word_index   last_word
//
//  Message bytes are absorbed while idle; a full 64-byte block then runs the
//  load, 80 rounds on one round unit and the chaining add.
//  A finish runs one padding byte a cycle outside its one or two compressions,
//  then five digest transfers, one per cycle while m_tready stays high.
//  s_tready is high only in the idle state; m_tready low holds the digest word.
//  Reset loads the initial chaining value and clears the byte counts.
`default_nettype none
module sha1_stream_hash_top
  import sha1s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] has_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] digest_word
  output logic [IDX_W-1:0] m_tuser,   // [2:0] word_index
  output logic             m_tlast
);

  cmd_t    cmd;
  status_t status;

  sha1s_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_has_byte (s_tuser),
    .in_finish   (s_tlast),
    .in_ready    (s_tready),
    .status      (status),
    .cmd         (cmd)
  );

  sha1s_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_index (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

/* design/sha1s_ctrl.sv */
// Controller state machine: absorb, padding, compression sequencing, digest output.
`default_nettype none
`include "assert_macros.svh"
module sha1s_ctrl
  import sha1s_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_has_byte,
  input  wire logic    in_finish,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t              state, state_next;
  state_t              ret_state, ret_state_next;
  logic [ROUND_W-1:0]  round_cnt;
  logic [IDX_W-1:0]    word_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      round_cnt <= '0;
      word_cnt  <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      if (state == S_ROUND) begin
        round_cnt <= round_cnt + 1'b1;
      end else begin
        round_cnt <= '0;
      end
      if (cmd.out_load) begin
        word_cnt <= (word_cnt == LAST_WORD_IDX) ? '0 : word_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte && status.fill_last) begin
            state_next     = S_LOAD;
            ret_state_next = in_finish ? S_PAD_MARK : S_IDLE;
          end else if (in_finish) begin
            state_next = S_PAD_MARK;
          end
        end
      end
      S_LOAD:  state_next = S_ROUND;
      S_ROUND: begin
        if (round_cnt == ROUND_W'(ROUNDS - 1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD:   state_next = ret_state;
      S_PAD_MARK: begin
        if (status.fill_last) begin
          state_next     = S_LOAD;
          ret_state_next = S_PAD_ZERO;
        end else begin
          state_next = S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        if (status.fill_at_len) begin
          state_next = S_PAD_LEN;
        end else if (status.fill_last) begin
          state_next     = S_LOAD;
          ret_state_next = S_PAD_ZERO;
        end
      end
      S_PAD_LEN: begin
        if (status.fill_last) begin
          state_next     = S_LOAD;
          ret_state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free && word_cnt == LAST_WORD_IDX) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cmd.byte_sel = BYTE_IN;
    cmd.phase    = PH_CH;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.absorb     = in_valid && in_has_byte;
        cmd.count_byte = in_valid && in_has_byte;
      end
      S_LOAD:  cmd.load_work = 1'b1;
      S_ROUND: begin
        cmd.round = 1'b1;
        if (round_cnt < ROUND_W'(20)) begin
          cmd.phase = PH_CH;
        end else if (round_cnt < ROUND_W'(40)) begin
          cmd.phase = PH_PAR1;
        end else if (round_cnt < ROUND_W'(60)) begin
          cmd.phase = PH_MAJ;
        end else begin
          cmd.phase = PH_PAR2;
        end
      end
      S_ADD: cmd.add_chain = 1'b1;
      S_PAD_MARK: begin
        cmd.absorb   = 1'b1;
        cmd.byte_sel = BYTE_MARK;
      end
      S_PAD_ZERO: begin
        cmd.absorb   = 1'b1;
        cmd.byte_sel = status.fill_at_len ? BYTE_LEN : BYTE_ZERO;
      end
      S_PAD_LEN: begin
        cmd.absorb   = 1'b1;
        cmd.byte_sel = BYTE_LEN;
      end
      S_EMIT: begin
        cmd.out_load  = status.out_free;
        cmd.out_index = word_cnt;
        cmd.init      = status.out_free && (word_cnt == LAST_WORD_IDX);
      end
      default: ;
    endcase
  end

  `CHK_ASSERT(a_round_range, clk, rst, (state == S_ROUND) |-> (round_cnt < ROUND_W'(ROUNDS)))
  `CHK_ASSERT(a_round_end, clk, rst, (state == S_ROUND && round_cnt == ROUND_W'(ROUNDS - 1)) |=> (state == S_ADD))
  `CHK_ASSERT(a_emit_free, clk, rst, cmd.out_load |-> status.out_free)

endmodule
`default_nettype wire

/* design/sha1s_datapath.sv */
// Datapath: block packing, message schedule window, round unit, chaining and output register.
`default_nettype none
`include "assert_macros.svh"
module sha1s_datapath
  import sha1s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  in_byte,
  input  wire cmd_t        cmd,
  output status_t          status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_word,
  output logic [IDX_W-1:0] out_index,
  output logic             out_last
);

  logic [31:0]       win [BLOCK_WORDS];
  logic [31:0]       chain [DIGEST_WORDS];
  logic [31:0]       a, b, c, d, e;
  logic [FILL_W-1:0] fill;
  logic [31:0]       msg_bytes;
  logic [7:0]        abs_byte;
  logic [7:0]        len_byte;
  logic [31:0]       f_val;
  logic [31:0]       k_val;
  logic [31:0]       t_val;
  logic [31:0]       sched;
  logic [3:0]        word_sel;
  logic [1:0]        lane;

  assign word_sel = fill[5:2];
  assign lane     = fill[1:0];

  always_comb begin
    unique case (fill[2:0])
      3'd3:    len_byte = {5'b0, msg_bytes[31:29]};
      3'd4:    len_byte = msg_bytes[28:21];
      3'd5:    len_byte = msg_bytes[20:13];
      3'd6:    len_byte = msg_bytes[12:5];
      3'd7:    len_byte = {msg_bytes[4:0], 3'b0};
      default: len_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (cmd.byte_sel)
      BYTE_IN:   abs_byte = in_byte;
      BYTE_MARK: abs_byte = PAD_MARK;
      BYTE_ZERO: abs_byte = 8'h00;
      BYTE_LEN:  abs_byte = len_byte;
      default:   abs_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (cmd.phase)
      PH_CH: begin
        f_val = d ^ (b & (c ^ d));
        k_val = K_CH;
      end
      PH_PAR1: begin
        f_val = b ^ c ^ d;
        k_val = K_PAR1;
      end
      PH_MAJ: begin
        f_val = (b & c) | (d & (b | c));
        k_val = K_MAJ;
      end
      PH_PAR2: begin
        f_val = b ^ c ^ d;
        k_val = K_PAR2;
      end
      default: begin
        f_val = '0;
        k_val = '0;
      end
    endcase
  end

  assign t_val = f_val + k_val + {a[26:0], a[31:27]} + e + win[0];

  always_comb begin
    logic [31:0] x;
    x     = win[13] ^ win[8] ^ win[2] ^ win[0];
    sched = {x[30:0], x[31]};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      if (cmd.round) begin
        win[i] <= (i == BLOCK_WORDS - 1) ? sched : win[(i + 1) % BLOCK_WORDS];
      end else if (cmd.absorb && word_sel == 4'(i)) begin
        unique case (lane)
          2'd0: win[i] <= {abs_byte, 24'h0};
          2'd1: win[i][23:16] <= abs_byte;
          2'd2: win[i][15:8]  <= abs_byte;
          2'd3: win[i][7:0]   <= abs_byte;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      a <= t_val;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= H_INIT[i];
      end
      fill      <= '0;
      msg_bytes <= '0;
    end else begin
      if (cmd.add_chain) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (cmd.absorb) begin
        fill <= fill + 1'b1;
      end
      if (cmd.count_byte) begin
        msg_bytes <= msg_bytes + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word  <= chain[cmd.out_index];
      out_index <= cmd.out_index;
      out_last  <= (cmd.out_index == LAST_WORD_IDX);
    end
  end

  assign status.fill_last   = (fill == FILL_LAST);
  assign status.fill_at_len = (fill == LEN_FILL);
  assign status.out_free    = !out_valid || out_ready;

  `CHK_ASSERT(a_round_block_empty, clk, rst, cmd.round |-> (fill == '0))
  `CHK_ASSERT(a_last_index, clk, rst, (out_valid && out_last) |-> (out_index == LAST_WORD_IDX))
  `CHK_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (fill == '0 && !out_valid))

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking stream testbench for the SHA-1 hash engine, with its own digest prediction.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1s_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct packed {
    logic [31:0]      word;
    logic [IDX_W-1:0] index;
    logic             last;
  } digest_out_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // [7:0] data_byte
  logic             s_tuser;   // [0] has_byte
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;   // [31:0] digest_word
  logic [IDX_W-1:0] m_tuser;   // [2:0] word_index
  logic             m_tlast;

  digest_out_t   digest_q [$];
  logic [31:0]   blk_w [BLOCK_WORDS];
  logic [31:0]   chain_h [DIGEST_WORDS];
  int unsigned   blk_fill;
  logic [31:0]   msg_len;
  int            send_idle_pct;
  int            recv_idle_pct;
  int unsigned   errors = 0;
  int unsigned   stalled = 0;

  sha1_stream_hash_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void hash_reset();
    foreach (chain_h[i]) chain_h[i] = H_INIT[i];
    foreach (blk_w[i]) blk_w[i] = 32'h0;
    blk_fill = 0;
    msg_len  = 32'h0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, t;
    foreach (w[i]) w[i] = blk_w[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < ROUNDS; r++) begin
      if (r >= 16) begin
        w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
      end
      if (r < 20) begin
        f = (d ^ (b & (c ^ d))) + K_CH;
      end else if (r < 40) begin
        f = (b ^ c ^ d) + K_PAR1;
      end else if (r < 60) begin
        f = ((b & c) | (d & (b | c))) + K_MAJ;
      end else begin
        f = (b ^ c ^ d) + K_PAR2;
      end
      t = f + rotl(a, 5) + e + w[r % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    int unsigned shift;
    shift = (3 - blk_fill % 4) * 8;
    if (blk_fill % 4 == 0) begin
      blk_w[blk_fill / 4] = 32'(value) << shift;
    end else begin
      blk_w[blk_fill / 4] |= 32'(value) << shift;
    end
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void predict_digest(input logic [7:0] data, input logic has,
                                         input logic fin);
    logic [31:0] n;
    if (has) begin
      msg_len++;
      absorb_byte(data);
    end
    if (fin) begin
      n = msg_len;
      absorb_byte(PAD_MARK);
      while (blk_fill != LEN_FILL) absorb_byte(8'h00);
      repeat (3) absorb_byte(8'h00);
      absorb_byte({5'b0, n[31:29]});
      absorb_byte(n[28:21]);
      absorb_byte(n[20:13]);
      absorb_byte(n[12:5]);
      absorb_byte({n[4:0], 3'b000});
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        digest_q.push_back(digest_out_t'{chain_h[k], IDX_W'(k), IDX_W'(k) == LAST_WORD_IDX});
      end
      hash_reset();
    end
  endfunction

  task automatic send_transfer(input logic [7:0] data, input logic has, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_digest(data, has, fin);
  endtask

  // hold the sender until every digest word is back
  task automatic drain_digests();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    logic joined;
    joined = (len != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_transfer(8'($urandom), 1'b0, 1'b0);
      send_transfer(8'($urandom), 1'b1, joined && (i == len - 1));
    end
    if (!joined) send_transfer(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned boundary [7] = '{54, 55, 56, 57, 63, 64, 65};
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(40);
      6, 7: return boundary[$urandom_range(6)];
      8: return $urandom_range(130, 100);
      default: return $urandom_range(1);
    endcase
  endfunction

  task automatic test_known_vectors();
    send_transfer(8'h5a, 1'b0, 1'b1);
    drain_digests();
    send_transfer("a", 1'b1, 1'b0);
    send_transfer("b", 1'b1, 1'b0);
    send_transfer("c", 1'b1, 1'b1);
    drain_digests();
  endtask

  task automatic test_byte_extremes();
    send_transfer(8'hff, 1'b1, 1'b0);
    send_transfer(8'ha5, 1'b0, 1'b0);
    send_transfer(8'h00, 1'b1, 1'b0);
    send_transfer(8'h3c, 1'b0, 1'b0);
    send_transfer(8'hff, 1'b0, 1'b1);
    send_transfer(8'h00, 1'b1, 1'b1);
    send_transfer(8'hff, 1'b1, 1'b1);
    drain_digests();
  endtask

  task automatic test_random_messages(input int s_pct, input int r_pct,
                                      input int unsigned quota);
    int unsigned sent;
    int unsigned msgs;
    int unsigned len;
    drain_digests();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    msgs = 0;
    while (sent < quota || msgs < 4) begin
      len = pick_length();
      send_message(len);
      sent += len + 1;
      msgs++;
    end
    drain_digests();
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    digest_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest transfer %h index %0d last %b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = digest_q.pop_front();
        if (m_tdata !== want.word || m_tuser !== want.index || m_tlast !== want.last) begin
          errors++;
          $display("%0t: digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
                   $time, want.word, want.index, want.last, m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled = 0;
    end else begin
      stalled++;
      if (stalled >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stalled);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tuser       = 1'b0;
    s_tlast       = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 80;
    hash_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_known_vectors();
    test_byte_extremes();
    test_random_messages(35, 80, 165);
    test_random_messages(80, 35, 165);
    test_random_messages(0, 0, 170);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
